// File: hw/rtl/depth_to_color_map_core_assert.svh
// Assertion macros for the depth to color map core.
// Each macro assumes a clock named clk and a synchronous active high reset named rst.
`ifndef DEPTH_TO_COLOR_MAP_CORE_ASSERT_SVH
`define DEPTH_TO_COLOR_MAP_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define D2C_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define D2C_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/d2c_pkg.sv
// Shared types and constants of the depth to color map core.
// No dependencies; every other RTL file of the core imports this package.
package d2c_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int REG_BITS        = 16;
  localparam int REG_INDEX_BITS  = 3;
  localparam int Q_BITS          = 11;
  localparam int CHAN_BITS       = 8;

  localparam logic [REG_INDEX_BITS-1:0] REG_MAP_MODE   = 3'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_GRAY_LOW   = 3'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_GRAY_HIGH  = 3'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_DEPTH_LOW  = 3'd3;
  localparam logic [REG_INDEX_BITS-1:0] REG_DEPTH_HIGH = 3'd4;

  // Full scale of the gray ramp and of the five-segment color ramp.
  localparam logic [Q_BITS-1:0] GRAY_FULL  = 11'd255;
  localparam logic [Q_BITS-1:0] COLOR_FULL = 11'd1275;

  // Upper ends of the first four color segments.
  localparam logic [Q_BITS-1:0] SEG_1 = 11'd255;
  localparam logic [Q_BITS-1:0] SEG_2 = 11'd510;
  localparam logic [Q_BITS-1:0] SEG_3 = 11'd765;
  localparam logic [Q_BITS-1:0] SEG_4 = 11'd1020;

  localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'hFF;

  typedef enum logic [1:0] {
    KIND_RAMP  = 2'd0,
    KIND_LOW   = 2'd1,
    KIND_HIGH  = 2'd2,
    KIND_BLACK = 2'd3
  } kind_t;

  typedef struct packed {
    logic  color;
    kind_t kind;
  } tag_t;

  typedef struct packed {
    logic                map_mode;
    logic [REG_BITS-1:0] gray_low;
    logic [REG_BITS-1:0] gray_high;
    logic [REG_BITS-1:0] depth_low;
    logic [REG_BITS-1:0] depth_high;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    map_mode:   1'b1,
    gray_low:   16'd0,
    gray_high:  16'd200,
    depth_low:  16'd0,
    depth_high: 16'd7500
  };

  // Red sits in the lowest bits.
  typedef struct packed {
    logic [CHAN_BITS-1:0] blue;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] red;
  } pixel_t;

endpackage

// File: hw/rtl/d2c_prep.sv
// Front end of the depth to color map core: range classification and scaled numerator.
// Two register stages; depends on d2c_pkg.
module d2c_prep #(
  parameter int SAMPLE_BITS = d2c_pkg::SAMPLE_BITS_DEF,
  localparam int CMP_BITS = (SAMPLE_BITS > d2c_pkg::REG_BITS) ? SAMPLE_BITS
                                                               : d2c_pkg::REG_BITS,
  localparam int NUM_BITS = CMP_BITS + d2c_pkg::Q_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ce,
  input  logic                 in_valid,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  d2c_pkg::cfg_t        cfg,
  output logic                 out_valid,
  output logic [NUM_BITS-1:0]  out_num,
  output logic [CMP_BITS-1:0]  out_den,
  output d2c_pkg::tag_t        out_tag
);
  import d2c_pkg::*;

  logic [CMP_BITS-1:0] v;
  logic [CMP_BITS-1:0] lo;
  logic [CMP_BITS-1:0] hi;
  kind_t               kind;

  logic                a_valid;
  tag_t                a_tag;
  logic [CMP_BITS-1:0] a_diff;
  logic [CMP_BITS-1:0] a_den;
  logic [Q_BITS-1:0]   full;

  always_comb begin
    v  = CMP_BITS'(in_sample);
    lo = cfg.map_mode ? CMP_BITS'(cfg.depth_low)  : CMP_BITS'(cfg.gray_low);
    hi = cfg.map_mode ? CMP_BITS'(cfg.depth_high) : CMP_BITS'(cfg.gray_high);
    // An empty range (high equal to low) scales to zero, which maps like a low sample.
    priority if (cfg.map_mode && v == '0) begin
      kind = KIND_BLACK;
    end else if (v < lo) begin
      kind = KIND_LOW;
    end else if (v > hi) begin
      kind = KIND_HIGH;
    end else if (hi == lo) begin
      kind = KIND_LOW;
    end else begin
      kind = KIND_RAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (ce) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_tag  <= '{color: cfg.map_mode, kind: kind};
      a_diff <= v - lo;
      a_den  <= hi - lo;
    end
  end

  assign full = a_tag.color ? COLOR_FULL : GRAY_FULL;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_num <= NUM_BITS'(a_diff) * NUM_BITS'(full);
      out_den <= a_den;
      out_tag <= a_tag;
    end
  end

endmodule

// File: hw/rtl/d2c_div.sv
// Pipelined restoring divider of the depth to color map core, one quotient bit per stage.
// The quotient stays within the ramp's full scale only for ramp samples; depends on d2c_pkg.
module d2c_div #(
  parameter int WIDTH = d2c_pkg::REG_BITS,
  localparam int NUM_BITS = WIDTH + d2c_pkg::Q_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ce,
  input  logic                      in_valid,
  input  logic [NUM_BITS-1:0]       in_num,
  input  logic [WIDTH-1:0]          in_den,
  input  d2c_pkg::tag_t             in_tag,
  output logic                      out_valid,
  output logic [d2c_pkg::Q_BITS-1:0] out_quo,
  output d2c_pkg::tag_t             out_tag
);
  import d2c_pkg::*;

  logic              vld [Q_BITS+1];
  logic [Q_BITS-1:0] quo [Q_BITS+1];
  tag_t              tag [Q_BITS+1];
  logic [WIDTH-1:0]  rem [Q_BITS];
  logic [Q_BITS-1:0] low [Q_BITS];
  logic [WIDTH-1:0]  den [Q_BITS];

  // For ramp samples the top bits of the numerator are below the divisor, as the quotient fits Q_BITS.
  assign vld[0] = in_valid;
  assign quo[0] = '0;
  assign tag[0] = in_tag;
  assign rem[0] = in_num[NUM_BITS-1:Q_BITS];
  assign low[0] = in_num[Q_BITS-1:0];
  assign den[0] = in_den;

  for (genvar k = 0; k < Q_BITS; k++) begin : g_step
    logic [WIDTH:0] trial;
    logic [WIDTH:0] diff;
    logic           fits;

    assign trial = {rem[k], low[k][Q_BITS-1]};
    assign diff  = trial - {1'b0, den[k]};
    assign fits  = trial >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ce) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        quo[k+1] <= {quo[k][Q_BITS-2:0], fits};
        tag[k+1] <= tag[k];
      end
    end

    if (k < Q_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ce) begin
          rem[k+1] <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
          low[k+1] <= {low[k][Q_BITS-2:0], 1'b0};
          den[k+1] <= den[k];
        end
      end
    end
  end

  assign out_valid = vld[Q_BITS];
  assign out_quo   = quo[Q_BITS];
  assign out_tag   = tag[Q_BITS];

endmodule

// File: hw/rtl/d2c_ramp.sv
// Color stage of the depth to color map core: turns the scaled value into an RGB pixel.
// One register stage; depends on d2c_pkg.
module d2c_ramp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ce,
  input  logic                       in_valid,
  input  logic [d2c_pkg::Q_BITS-1:0] in_quo,
  input  d2c_pkg::tag_t              in_tag,
  output logic                       out_valid,
  output d2c_pkg::pixel_t            out_pixel
);
  import d2c_pkg::*;

  pixel_t px;

  always_comb begin
    px = '0;
    unique case (in_tag.kind)
      KIND_BLACK: begin
        px = '0;
      end
      KIND_LOW: begin
        if (in_tag.color) begin
          px.red = CHAN_MAX;
        end
      end
      KIND_HIGH: begin
        px.red  = CHAN_MAX;
        px.blue = CHAN_MAX;
        if (!in_tag.color) begin
          px.green = CHAN_MAX;
        end
      end
      KIND_RAMP: begin
        if (!in_tag.color) begin
          px.red   = in_quo[CHAN_BITS-1:0];
          px.green = in_quo[CHAN_BITS-1:0];
          px.blue  = in_quo[CHAN_BITS-1:0];
        end else begin
          priority if (in_quo <= SEG_1) begin
            px.red   = CHAN_MAX;
            px.green = in_quo[CHAN_BITS-1:0];
          end else if (in_quo <= SEG_2) begin
            px.red   = CHAN_BITS'(SEG_2 - in_quo);
            px.green = CHAN_MAX;
          end else if (in_quo <= SEG_3) begin
            px.green = CHAN_MAX;
            px.blue  = CHAN_BITS'(in_quo - SEG_2);
          end else if (in_quo <= SEG_4) begin
            px.green = CHAN_BITS'(SEG_4 - in_quo);
            px.blue  = CHAN_MAX;
          end else begin
            px.red   = CHAN_BITS'(in_quo - SEG_4);
            px.blue  = CHAN_MAX;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_pixel <= px;
    end
  end

endmodule

// File: hw/rtl/depth_to_color_map_core.sv
// Depth to color map core: one 16-bit camera sample in, one RGB888 pixel out per word.
// Throughput is one word per cycle while the skid register is free; the pipeline runs from the
// classification and multiply stages through the 11-stage divider (one quotient bit per stage)
// to the color stage, then the output register.
// Synchronous reset empties the pipeline and loads the register defaults; no clearing pass.
`include "depth_to_color_map_core_assert.svh"

module depth_to_color_map_core #(
  parameter int SAMPLE_BITS = d2c_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [d2c_pkg::REG_INDEX_BITS-1:0]  wr_index,
  input  logic [d2c_pkg::REG_BITS-1:0]        wr_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // sample in the low SAMPLE_BITS bits, zero padded to whole bytes
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [3 * d2c_pkg::CHAN_BITS - 1:0] m_tdata
);
  import d2c_pkg::*;

  localparam int CMP_BITS = (SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS;
  localparam int NUM_BITS = CMP_BITS + Q_BITS;

  cfg_t                cfg;
  logic                ce;

  logic                f_valid;
  logic [NUM_BITS-1:0] f_num;
  logic [CMP_BITS-1:0] f_den;
  tag_t                f_tag;

  logic                d_valid;
  logic [Q_BITS-1:0]   d_quo;
  tag_t                d_tag;

  logic                p_valid;
  pixel_t              p_pixel;

  pixel_t              m_pixel;
  logic                skid_valid;
  pixel_t              skid_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MAP_MODE:   cfg.map_mode   <= wr_data[0];
        REG_GRAY_LOW:   cfg.gray_low   <= wr_data;
        REG_GRAY_HIGH:  cfg.gray_high  <= wr_data;
        REG_DEPTH_LOW:  cfg.depth_low  <= wr_data;
        REG_DEPTH_HIGH: cfg.depth_high <= wr_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves while the skid register is free.
  assign ce       = !skid_valid;
  assign s_tready = ce;

  d2c_prep #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .in_sample (s_tdata[SAMPLE_BITS-1:0]),
    .cfg       (cfg),
    .out_valid (f_valid),
    .out_num   (f_num),
    .out_den   (f_den),
    .out_tag   (f_tag)
  );

  d2c_div #(
    .WIDTH(CMP_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (f_valid),
    .in_num    (f_num),
    .in_den    (f_den),
    .in_tag    (f_tag),
    .out_valid (d_valid),
    .out_quo   (d_quo),
    .out_tag   (d_tag)
  );

  d2c_ramp u_ramp (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (d_valid),
    .in_quo    (d_quo),
    .in_tag    (d_tag),
    .out_valid (p_valid),
    .out_pixel (p_pixel)
  );

  // Output register with a skid word behind it, so a stalled output does not stop intake
  // until a second word is waiting.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (skid_valid) begin
        if (m_tready) begin
          m_tvalid   <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (!m_tvalid || m_tready) begin
        m_tvalid <= p_valid;
      end else begin
        skid_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_valid) begin
      if (m_tready) begin
        m_pixel <= skid_pixel;
      end
    end else if (!m_tvalid || m_tready) begin
      m_pixel <= p_pixel;
    end else begin
      skid_pixel <= p_pixel;
    end
  end

  assign m_tdata = m_pixel;

  `D2C_ASSERT_NOW(a_skid_behind_out, skid_valid, m_tvalid, "skid word held without an output word")
  `D2C_ASSERT_NEXT(a_stall_to_skid, m_tvalid && !m_tready && p_valid && !skid_valid, skid_valid, "stalled pixel was not kept in the skid register")
  `D2C_ASSERT_NEXT(a_skid_drains, skid_valid && m_tready, m_tvalid && !skid_valid, "skid word did not move to the output")

endmodule
